FILE: src/ibq_pkg.sv
package ibq_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int IDX_W      = 6;
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int SHIFT_W    = 5;
  localparam int SECTIONS_W = 4;
  localparam int PROD_W     = DATA_W + COEF_W;
  // five products of PROD_W bits; four guard bits cover the sum
  localparam int ACC_W      = PROD_W + 4;

  // Stream and configuration port widths
  localparam int S_TDATA_W  = 40;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Bit positions inside s_tdata
  localparam int SAMPLE_LSB = 0;
  localparam int IDX_LSB    = SAMPLE_LSB + SAMPLE_W;
  localparam int COEF_LSB   = IDX_LSB + IDX_W;

  // Table layout per section: b0 b1 b2 a0 a1 a2, and x0 x1 x2 y1 y2
  localparam int COEF_PER_SEC  = 6;
  localparam int DELAY_PER_SEC = 5;
  localparam int SLOT_A0       = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GAIN     = 2'd0;
  localparam cfg_idx_t CFG_SHIFT    = 2'd1;
  localparam cfg_idx_t CFG_SECTIONS = 2'd2;

  localparam logic signed [GAIN_W-1:0] GAIN_RST     = 16'sh7FFF;
  localparam logic [SHIFT_W-1:0]       SHIFT_RST    = 5'd15;
  localparam logic [SECTIONS_W-1:0]    SECTIONS_RST = 4'd1;

  localparam logic ACTION_FILTER = 1'b0;
  localparam logic ACTION_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Steps of the per-section sequence
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_FIRST     = 4'd0;
  localparam step_t STEP_MUL_X0    = 4'd1;
  localparam step_t STEP_ACC_FIRST = 4'd2;
  localparam step_t STEP_HOLD_A    = 4'd2;
  localparam step_t STEP_HOLD_B    = 4'd4;
  localparam step_t STEP_SUB_FIRST = 4'd5;
  localparam step_t STEP_ACC_LAST  = 4'd6;
  localparam step_t STEP_Y         = 4'd7;
  localparam step_t STEP_GAIN      = 4'd8;
  localparam step_t STEP_LAST      = 4'd9;
  localparam step_t STEP_WR_X0     = 4'd5;
  localparam step_t STEP_WR_X1     = 4'd6;
  localparam step_t STEP_WR_X2     = 4'd7;
  localparam step_t STEP_WR_Y1     = 4'd8;
  localparam step_t STEP_WR_Y2     = 4'd9;

endpackage

FILE: src/iir_biquad_cascade_df1.sv
// A sample word runs the ten-step section sequence for each of n active sections
//   (n capped at MAX_SECTIONS); with n = 0 the sample passes straight through. The steps
//   share the single 32x16 multiplier and the one read port of each table, and no new
//   sample is taken until the result is loaded; coefficient words never make it busy.
//   Synchronous active-high reset: delay line reads as zero at once, registers return
//   to gain 32767, shift 15, one section; coefficients stay unset.
module iir_biquad_cascade_df1 #(
  parameter int MAX_SECTIONS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_in [15:0], coef_index [21:16], coef_value [37:22], zero [39:38]
  input  logic [ibq_pkg::S_TDATA_W-1:0]     s_tdata,
  // action [0]
  input  logic [ibq_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // filtered_out [31:0]
  output logic [ibq_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                              cfg_we,
  input  logic [ibq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ibq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import ibq_pkg::*;

  localparam int COEF_WORDS  = COEF_PER_SEC * MAX_SECTIONS;
  localparam int DELAY_WORDS = DELAY_PER_SEC * MAX_SECTIONS;
  localparam int CA_W        = $clog2(COEF_WORDS);
  localparam int DA_W        = $clog2(DELAY_WORDS);
  localparam int SEC_W       = $clog2(MAX_SECTIONS + 1);
  localparam int CMP_W       = (SEC_W > SECTIONS_W) ? SEC_W : SECTIONS_W;

  // Input word fields
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [IDX_W-1:0]           coef_index;
  logic [COEF_W-1:0]          coef_value;

  assign sample_in  = s_tdata[SAMPLE_LSB +: SAMPLE_W];
  assign coef_index = s_tdata[IDX_LSB +: IDX_W];
  assign coef_value = s_tdata[COEF_LSB +: COEF_W];

  // Configuration registers
  logic signed [GAIN_W-1:0] gain;
  logic [SHIFT_W-1:0]       shamt;
  logic [SECTIONS_W-1:0]    active;

  // Sequencer
  state_t         state, state_next;
  step_t          step, step_next;
  logic [SEC_W-1:0] sec, n_sec, n_now;
  logic [CA_W-1:0]  cbase;
  logic [DA_W-1:0]  dbase;
  logic           sample_go, sec_adv, out_load, last_sec;
  logic [CMP_W-1:0] act_ext;

  // Datapath
  logic signed [DATA_W-1:0] xn, y, hold_a, hold_b, dly_q, mul_a, sh_res;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, prod_ext, sh_in, sh_out;
  logic [DATA_W-1:0]        out_data;
  logic                     out_valid;

  // Table ports
  logic              coef_we;
  logic [CA_W-1:0]   coef_waddr, coef_raddr;
  logic [COEF_W-1:0] coef_rdata;
  step_t             coef_slot;
  logic              dly_we;
  logic [DA_W-1:0]   dly_waddr, dly_raddr;
  logic [DATA_W-1:0] dly_wdata, dly_rdata;
  logic [DELAY_WORDS-1:0] dvalid;
  logic              dvalid_q;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Clamp the section count to what the tables hold
  assign act_ext  = CMP_W'(active);
  assign n_now    = (act_ext > CMP_W'(MAX_SECTIONS)) ? SEC_W'(MAX_SECTIONS) : SEC_W'(act_ext);
  assign last_sec = (SEC_W'(sec + 1'b1) == n_sec);

  // ---------------------------------------------------------------------------
  // Coefficient table: loaded straight from the input word, read by the sequencer.
  // Loads beyond the table are dropped.
  // ---------------------------------------------------------------------------
  assign coef_we    = (state == ST_IDLE) && s_tvalid && (s_tuser[0] == ACTION_LOAD) &&
                      (32'(coef_index) < 32'(COEF_WORDS));
  assign coef_waddr = CA_W'(coef_index);

  // Steps 0..4 fetch b0 b1 b2 a1 a2; skip the unused a0 slot
  always_comb begin
    if (step < STEP_W'(SLOT_A0)) begin
      coef_slot = step;
    end else begin
      coef_slot = step + 1'b1;
    end
  end
  assign coef_raddr = cbase + CA_W'(coef_slot);

  ibq_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_WORDS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // ---------------------------------------------------------------------------
  // Delay line: steps 1..4 read x1 x2 y1 y2, steps 5..9 write x0 x1 x2 y1 y2.
  // A word never written since reset reads as zero through its valid bit.
  // ---------------------------------------------------------------------------
  assign dly_raddr = dbase + DA_W'(step);
  assign dly_waddr = dbase + DA_W'(step - STEP_WR_X0);
  assign dly_we    = (state == ST_RUN) && (step >= STEP_WR_X0);

  always_comb begin
    case (step)
      STEP_WR_X0: dly_wdata = xn;
      STEP_WR_X1: dly_wdata = xn;
      STEP_WR_X2: dly_wdata = hold_a;   // old x1 moves down
      STEP_WR_Y1: dly_wdata = y;
      STEP_WR_Y2: dly_wdata = hold_b;   // old y1 moves down
      default:    dly_wdata = xn;
    endcase
  end

  ibq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DELAY_WORDS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  assign dly_q = dvalid_q ? dly_rdata : '0;

  // ---------------------------------------------------------------------------
  // Shared multiplier: b0*x0 at step 1, delay taps at steps 2..5, gain at step 8.
  // Shared shifter: accumulator at step 7, gain product at step 9.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (step)
      STEP_MUL_X0: begin
        mul_a = xn;
        mul_b = coef_rdata;
      end
      STEP_GAIN: begin
        mul_a = y;
        mul_b = gain;
      end
      default: begin
        mul_a = dly_q;
        mul_b = coef_rdata;
      end
    endcase
  end

  assign prod_ext = ACC_W'(prod);
  assign sh_in    = (step == STEP_Y) ? acc : prod_ext;
  assign sh_out   = sh_in >>> shamt;
  assign sh_res   = sh_out[DATA_W-1:0];   // wrap to 32 bits

  // ---------------------------------------------------------------------------
  // Sequencer: next state and strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    step_next  = step;
    sample_go  = 1'b0;
    sec_adv    = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && (s_tuser[0] != ACTION_LOAD)) begin
          sample_go  = 1'b1;
          step_next  = STEP_FIRST;
          // with no sections the sample passes straight through
          state_next = (n_now == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == STEP_LAST) begin
          step_next = STEP_FIRST;
          if (last_sec) begin
            state_next = ST_DONE;
          end else begin
            sec_adv = 1'b1;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_FIRST;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Control registers: configuration, section count, output handshake, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RST;
      shamt     <= SHIFT_RST;
      active    <= SECTIONS_RST;
      sec       <= '0;
      n_sec     <= '0;
      out_valid <= 1'b0;
      dvalid    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:     gain   <= cfg_wdata[GAIN_W-1:0];
          CFG_SHIFT:    shamt  <= cfg_wdata[SHIFT_W-1:0];
          CFG_SECTIONS: active <= cfg_wdata[SECTIONS_W-1:0];
          default: ;
        endcase
      end
      if (sample_go) begin
        sec   <= '0;
        n_sec <= n_now;
      end else if (sec_adv) begin
        sec <= sec + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (dly_we) begin
        dvalid[dly_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dvalid_q <= dvalid[dly_raddr];
    prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (sample_go) begin
      xn    <= DATA_W'(sample_in);
      cbase <= '0;
      dbase <= '0;
    end
    if (sec_adv) begin
      cbase <= cbase + CA_W'(COEF_PER_SEC);
      dbase <= dbase + DA_W'(DELAY_PER_SEC);
    end
    if (state == ST_RUN) begin
      if (step == STEP_HOLD_A) begin
        hold_a <= dly_q;
      end
      if (step == STEP_HOLD_B) begin
        hold_b <= dly_q;
      end
      // add the b terms, subtract the a terms
      if (step == STEP_ACC_FIRST) begin
        acc <= prod_ext;
      end else if (step > STEP_ACC_FIRST && step < STEP_SUB_FIRST) begin
        acc <= acc + prod_ext;
      end else if (step >= STEP_SUB_FIRST && step <= STEP_ACC_LAST) begin
        acc <= acc - prod_ext;
      end
      if (step == STEP_Y) begin
        y <= sh_res;
      end
      if (step == STEP_LAST) begin
        xn <= sh_res;   // gain output feeds the next section
      end
    end
    if (out_load) begin
      out_data <= xn;
    end
  end

endmodule

FILE: src/ibq_ram.sv
module ibq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ibq_checker.sv
module ibq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [ibq_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ibq_pkg::M_TDATA_W-1:0] m_tdata
);

  import ibq_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // a sample word makes the block busy
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == ACTION_FILTER) |=> !s_tready)
    else $error("block ready right after taking a sample");

  // a coefficient word leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == ACTION_LOAD) |=> s_tready)
    else $error("block busy after a coefficient load");

  // reset empties the output and readies the input
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset left the block busy or a result pending");

  // a new result appears together with the return to ready
  a_result_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result shown while a sample is still in work");

endmodule

bind iir_biquad_cascade_df1 ibq_checker u_ibq_checker (.*);

FILE: tb/tb_iir_biquad_cascade_df1.sv
module tb_iir_biquad_cascade_df1;
  timeunit 1ns;
  timeprecision 1ps;

  import ibq_pkg::*;

  localparam int MAX_SEC     = 8;
  localparam int TABLE_WORDS = COEF_PER_SEC * MAX_SEC;
  localparam int DELAY_WORDS = DELAY_PER_SEC * MAX_SEC;
  // longest sample walk runs every step for all MAX_SEC sections; leave some slack on top
  localparam int SETTLE      = 10 * MAX_SEC + 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS_PER_PHASE = 85;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  // sample_in [15:0], coef_index [21:16], coef_value [37:22], zero [39:38]
  logic [S_TDATA_W-1:0]     s_tdata = '0;
  // action [0]
  logic [S_TUSER_W-1:0]     s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  // filtered_out [31:0]
  logic [M_TDATA_W-1:0]     m_tdata;
  logic                     cfg_we = 1'b0;
  cfg_idx_t                 cfg_index = CFG_GAIN;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  // Shadow copy of the filter: coefficient table, delay line and registers
  logic signed [COEF_W-1:0] coef_tab  [TABLE_WORDS];
  logic signed [DATA_W-1:0] delay_tab [DELAY_WORDS];
  logic signed [GAIN_W-1:0] gain_reg;
  logic [SHIFT_W-1:0]       shift_reg;
  logic [SECTIONS_W-1:0]    sections_reg;

  // Filtered words still owed by the block, oldest first
  logic [DATA_W-1:0]        filtered_expect [$];
  logic [DATA_W-1:0]        want_word;

  int fail_count  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  iir_biquad_cascade_df1 #(
    .MAX_SECTIONS(MAX_SEC)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: stall at random according to the current phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("mismatch (%s): filtered_out expected %0d, got %0d at cycle %0d",
             what, $signed(want), $signed(got), cycle_count);
    fail_count++;
  endtask

  // Compare every word taken from the master side with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_expect.size() == 0) begin
        report_mismatch("word with nothing expected", '0, m_tdata);
      end else begin
        want_word = filtered_expect.pop_front();
        if (m_tdata !== want_word)
          report_mismatch("wrong filtered_out", want_word, m_tdata);
      end
    end
  end

  // Walk one sample through the active sections of the shadow filter.
  // Each section: x terms minus y terms in 64 bits, shift, wrap, then gain,
  // shift and wrap again before feeding the next section.
  function automatic logic [DATA_W-1:0] run_cascade(input logic signed [SAMPLE_W-1:0] smp);
    logic signed [63:0]       acc;
    logic signed [63:0]       stage_in;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] x0;
    int n;
    int c;
    int d;
    stage_in = smp;
    n = (sections_reg > MAX_SEC) ? MAX_SEC : int'(sections_reg);
    for (int k = 0; k < n; k++) begin
      c = COEF_PER_SEC * k;
      d = DELAY_PER_SEC * k;
      x0 = stage_in[DATA_W-1:0];
      delay_tab[d] = x0;
      acc = longint'(coef_tab[c])     * longint'(delay_tab[d])
          + longint'(coef_tab[c + 1]) * longint'(delay_tab[d + 1])
          + longint'(coef_tab[c + 2]) * longint'(delay_tab[d + 2]);
      delay_tab[d + 2] = delay_tab[d + 1];
      delay_tab[d + 1] = delay_tab[d];
      // a0 at slot 3 is skipped on purpose
      acc = acc - longint'(coef_tab[c + 4]) * longint'(delay_tab[d + 3])
                - longint'(coef_tab[c + 5]) * longint'(delay_tab[d + 4]);
      acc = acc >>> shift_reg;
      y = acc[DATA_W-1:0];
      delay_tab[d + 4] = delay_tab[d + 3];
      delay_tab[d + 3] = y;
      acc = (longint'(y) * longint'(gain_reg)) >>> shift_reg;
      x0 = acc[DATA_W-1:0];
      stage_in = x0;
    end
    return stage_in[DATA_W-1:0];
  endfunction

  // Offer one word on the slave side, hold it until taken, then update the
  // shadow filter. Leave tvalid high on return so back-to-back words flow.
  task automatic send_word(input logic act, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] cval);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, cval, idx, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (act == ACTION_LOAD) begin
      // indexes past the table are dropped by the block
      if (idx < TABLE_WORDS)
        coef_tab[idx] = cval;
    end else begin
      filtered_expect.push_back(run_cascade(smp));
    end
  endtask

  task automatic load_coef(input int idx, input logic [COEF_W-1:0] cval);
    send_word(ACTION_LOAD, SAMPLE_W'($urandom), IDX_W'(idx), cval);
  endtask

  task automatic filter_sample(input logic [SAMPLE_W-1:0] smp);
    send_word(ACTION_FILTER, smp, IDX_W'($urandom), COEF_W'($urandom));
  endtask

  // Drop tvalid, wait for every owed word, then give the block time to
  // finish any sample still in flight before registers change
  task automatic drain;
    s_tvalid <= 1'b0;
    while (filtered_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [SHIFT_W-1:0] shift,
                            input logic [SECTIONS_W-1:0] sections);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_wdata <= CFG_DATA_W'(gain);
    @(posedge clk);
    gain_reg = gain;
    cfg_index <= CFG_SHIFT;
    cfg_wdata <= CFG_DATA_W'(shift);
    @(posedge clk);
    shift_reg = shift;
    cfg_index <= CFG_SECTIONS;
    cfg_wdata <= CFG_DATA_W'(sections);
    @(posedge clk);
    sections_reg = sections;
    cfg_we <= 1'b0;
  endtask

  // Full-range words or small, filter-like ones, picked at random
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Load section 0 only, then filter with the settings the block wakes up in
  task automatic test_reset_settings;
    load_coef(0, 16'sd4096);
    load_coef(1, 16'sd8192);
    load_coef(2, 16'sd4096);
    load_coef(SLOT_A0, 16'sd16384);
    load_coef(4, -16'sd20000);
    load_coef(5, 16'sd8000);
    filter_sample(16'h7FFF);
    filter_sample(16'h8000);
    filter_sample(16'h0000);
    filter_sample(16'hFFFF);
  endtask

  // Loads beyond the table must leave it alone; a0 must have no effect
  task automatic test_ignored_coefs;
    load_coef(TABLE_WORDS, 16'h7FFF);
    load_coef(63, 16'h8000);
    load_coef(SLOT_A0, 16'h8000);
    filter_sample(16'h4000);
    filter_sample(16'hC000);
  endtask

  // Fill the rest of the table with extreme and random words, then cover
  // bypass, the full cascade, a count past the cap and the register extremes
  task automatic test_section_counts;
    for (int i = COEF_PER_SEC; i < TABLE_WORDS; i++) begin
      if (i < 2 * COEF_PER_SEC)
        load_coef(i, 16'h8000);
      else if (i < 3 * COEF_PER_SEC)
        load_coef(i, 16'h7FFF);
      else
        load_coef(i, pick_coef());
    end
    set_config(16'h7FFF, 5'd15, 4'd0);
    filter_sample(16'h8000);
    filter_sample(16'h7FFF);
    set_config(16'h8000, 5'd0, 4'd8);
    filter_sample(16'h7FFF);
    filter_sample(16'h8000);
    set_config(16'h0000, 5'd31, 4'd15);
    filter_sample(16'h7FFF);
    filter_sample(16'h0001);
    set_config(16'h7FFF, 5'd31, 4'd8);
    filter_sample(16'h8000);
  endtask

  // Long runs of samples with the odd coefficient reload and stray index,
  // under each idling pattern and a spread of register settings
  task automatic test_random_traffic;
    int counted;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          set_config(16'h7FFF, 5'd15, 4'd8);
        end
        1: begin
          idle_pct = 65; stall_pct = 0;
          set_config(16'h8000, 5'd0, 4'd3);
        end
        2: begin
          idle_pct = 0;  stall_pct = 65;
          set_config(16'h0000, 5'd31, 4'd15);
        end
        default: begin
          idle_pct = 37; stall_pct = 37;
          set_config(pick_gain(), SHIFT_W'($urandom), SECTIONS_W'($urandom));
        end
      endcase
      counted = 0;
      while (counted < RANDOM_ITEMS_PER_PHASE) begin
        // retune part way through each phase
        if (counted % 40 == 39)
          set_config(pick_gain(), SHIFT_W'($urandom_range(8, 20)), SECTIONS_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          filter_sample(SAMPLE_W'($urandom));
          counted++;
        end else if (pick < 97) begin
          load_coef($urandom_range(0, TABLE_WORDS - 1), pick_coef());
          counted++;
        end else begin
          load_coef($urandom_range(TABLE_WORDS, 63), COEF_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    // Mirror reset: delay line clear, default registers, table unset
    foreach (delay_tab[i]) delay_tab[i] = '0;
    foreach (coef_tab[i]) coef_tab[i] = '0;
    gain_reg     = GAIN_RST;
    shift_reg    = SHIFT_RST;
    sections_reg = SECTIONS_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_ignored_coefs();
    test_section_counts();
    test_random_traffic();

    idle_pct  = 0;
    stall_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: iir_biquad_cascade_df1.f
src/ibq_pkg.sv
src/ibq_ram.sv
src/iir_biquad_cascade_df1.sv
src/ibq_checker.sv
tb/tb_iir_biquad_cascade_df1.sv
